[rtl/brfo_pkg.sv]
`timescale 1ns / 1ps
package brfo_pkg;

    // Memory depth default and the width of the length register and occupancy.
    localparam int DEPTH_DEF = 64;
    localparam int LEN_W     = 7;

    // A get line reads at most this many bytes.
    localparam int MAX_LINE  = 64;
    localparam int CNT_W     = 7;

    localparam logic [7:0] CHAR_CR = 8'h0D;

    // Operation codes of the func field.
    localparam logic [1:0] FUNC_PUT  = 2'd0;
    localparam logic [1:0] FUNC_GET  = 2'd1;
    localparam logic [1:0] FUNC_LINE = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_in;
        logic [7:0] line_limit;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       data_out;
        logic             byte_valid;
        logic             overwrote;
        logic [7:0]       line_count;
        logic [LEN_W-1:0] occupancy;
        logic [LEN_W-1:0] free_space;
        logic             last;
    } out_item_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LINE
    } state_t;

endpackage

[rtl/byte_ring_fifo_overwrite_line_read_top.sv]
`timescale 1ns / 1ps
// Results: a put or get result is loaded into the output register by its item transfer;
// a get line first enters the line state, which then loads each of its results.
// Throughput: a put or get is taken as a single item; a get line enters the line state and
// then reads one byte per cycle while the output register is free (one empty result if it
// reads nothing), paced by the single memory read port that always presents the byte at the read pointer.
// Reset (aresetn, synchronous): FIFO empty, pointers zero, length register DEPTH.
module byte_ring_fifo_overwrite_line_read_top #(
    parameter int DEPTH = brfo_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  brfo_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output brfo_pkg::out_item_t           m_data,
    input  logic                          cfg_wr_en,
    input  logic [brfo_pkg::LEN_W-1:0]    cfg_wr_data
);
    import brfo_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Pointer step that wraps at the configured length.
    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                             input logic [LEN_W-1:0] len);
        logic [PTR_W:0] q;
        q = {1'b0, p} + 1'b1;
        if (int'(q) >= int'(len)) begin
            return '0;
        end
        return q[PTR_W-1:0];
    endfunction

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] budget_reg, budget_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rd_data_reg;
    logic             fwd_hit_reg;
    logic [7:0]       fwd_data_reg;
    logic             mem_we;
    logic [7:0]       cur_byte;

    logic             out_free;
    logic             out_load;
    out_item_t        res;
    logic [7:0]       lim_m1;
    logic [CNT_W-1:0] budget_calc;
    logic             is_cr;
    logic             fin;
    logic [CNT_W-1:0] cnt_upd;
    logic [LEN_W-1:0] cfg_len;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // The byte at the read pointer, with a write of the last cycle forwarded.
    assign cur_byte = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    // Length register value after clamping to 1..DEPTH.
    always_comb begin
        if (cfg_wr_data == '0) begin
            cfg_len = LEN_W'(1);
        end else if (int'(cfg_wr_data) > DEPTH) begin
            cfg_len = LEN_W'(DEPTH);
        end else begin
            cfg_len = cfg_wr_data;
        end
    end

    // Get line budget: limit minus one, capped at the longest line.
    always_comb begin
        lim_m1 = (s_data.line_limit == 8'd0) ? 8'd0 : s_data.line_limit - 8'd1;
        if (int'(lim_m1) > MAX_LINE) begin
            budget_calc = CNT_W'(MAX_LINE);
        end else begin
            budget_calc = lim_m1[CNT_W-1:0];
        end
    end

    // Next state, pointer updates and result formation.
    always_comb begin
        state_next  = state_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        budget_next = budget_reg;
        k_next      = k_reg;
        count_next  = count_reg;
        mem_we      = 1'b0;
        out_load    = 1'b0;
        res         = '0;
        is_cr       = (cur_byte == CHAR_CR);
        fin         = 1'b0;
        cnt_upd     = count_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    unique case (s_data.func)
                        FUNC_PUT: begin
                            mem_we      = 1'b1;
                            wr_ptr_next = adv(wr_ptr_reg, len_reg);
                            out_load    = 1'b1;
                            res.last    = 1'b1;
                            if (fill_reg >= len_reg) begin
                                res.overwrote = 1'b1;
                                rd_ptr_next   = adv(rd_ptr_reg, len_reg);
                            end else begin
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        FUNC_GET: begin
                            out_load = 1'b1;
                            res.last = 1'b1;
                            if (fill_reg != '0) begin
                                res.data_out   = cur_byte;
                                res.byte_valid = 1'b1;
                                rd_ptr_next    = adv(rd_ptr_reg, len_reg);
                                fill_next      = fill_reg - 1'b1;
                            end
                        end
                        FUNC_LINE: begin
                            budget_next = budget_calc;
                            k_next      = '0;
                            count_next  = '0;
                            state_next  = ST_LINE;
                        end
                        default: begin
                            out_load = 1'b1;
                            res.last = 1'b1;
                        end
                    endcase
                end
            end
            ST_LINE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (k_reg == '0 && (budget_reg == '0 || fill_reg == '0)) begin
                        // Nothing to read: one empty result.
                        res.last   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        rd_ptr_next    = adv(rd_ptr_reg, len_reg);
                        fill_next      = fill_reg - 1'b1;
                        cnt_upd        = is_cr ? count_reg : count_reg + 1'b1;
                        fin            = is_cr || ({1'b0, k_reg} + 1'b1 >= {1'b0, budget_reg})
                                         || (fill_next == '0);
                        res.data_out   = cur_byte;
                        res.byte_valid = 1'b1;
                        res.last       = fin;
                        res.line_count = fin ? 8'(cnt_upd) : 8'd0;
                        count_next     = cnt_upd;
                        k_next         = k_reg + 1'b1;
                        if (fin) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        res.occupancy  = fill_next;
        res.free_space = len_reg - fill_next;

        // A length write empties the FIFO; the user must issue it only while idle, the block does not enforce this.
        if (cfg_wr_en) begin
            len_next    = cfg_len;
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            fill_next   = '0;
        end
    end

    // Control and pointer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
            len_reg     <= LEN_W'(DEPTH);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            len_reg    <= len_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item working registers and the output payload.
    always_ff @(posedge aclk) begin
        budget_reg <= budget_next;
        k_reg      <= k_next;
        count_reg  <= count_next;
        if (out_load) begin
            m_data_reg <= res;
        end
    end

    // Byte store: one write port, one read port addressed by the next read pointer.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_ptr_reg] <= s_data.data_in;
        end
        rd_data_reg  <= mem[rd_ptr_next];
        fwd_hit_reg  <= mem_we && (wr_ptr_reg == rd_ptr_next);
        fwd_data_reg <= s_data.data_in;
    end

endmodule

[sim/tb_byte_ring_fifo_overwrite_line_read_top.sv]
`timescale 1ns / 1ps
module tb_byte_ring_fifo_overwrite_line_read_top;
    import brfo_pkg::*;

    // The func field has one code that the block treats as a no-op.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int RING_W      = $clog2(DEPTH_DEF);

    // Scoreboard: keeps its own copy of the ring and predicts every result.
    class fifo_scoreboard;
        logic [7:0]  ring [DEPTH_DEF];
        int unsigned wr_ptr;
        int unsigned rd_ptr;
        int unsigned fill;
        int unsigned slots;
        int unsigned errors;
        out_item_t   results_due[$];

        function new();
            slots  = DEPTH_DEF;
            wr_ptr = 0;
            rd_ptr = 0;
            fill   = 0;
            errors = 0;
        endfunction

        // A length write clamps the value into range and empties the ring.
        function void set_length(logic [LEN_W-1:0] v);
            if (v == 0) begin
                slots = 1;
            end else if (v > DEPTH_DEF) begin
                slots = DEPTH_DEF;
            end else begin
                slots = 32'(v);
            end
            wr_ptr = 0;
            rd_ptr = 0;
            fill   = 0;
        endfunction

        function int unsigned next_slot(int unsigned p);
            return (p + 1 >= slots) ? 0 : p + 1;
        endfunction

        function void push_result(logic [7:0] b, logic vld, logic ovr, logic [7:0] cnt,
                                  logic lst);
            out_item_t r;
            r.data_out   = b;
            r.byte_valid = vld;
            r.overwrote  = ovr;
            r.line_count = cnt;
            r.occupancy  = fill[LEN_W-1:0];
            r.free_space = LEN_W'(slots - fill);
            r.last       = lst;
            results_due.push_back(r);
        endfunction

        // Called on every input transfer; queues the results that it causes.
        function void note_request(in_item_t it);
            int unsigned budget;
            int unsigned count;
            int unsigned nread;
            logic [7:0]  b;
            logic        ovr;
            bit          is_cr;
            bit          done;
            case (it.func)
                FUNC_PUT: begin
                    ovr = 1'b0;
                    if (fill >= slots) begin
                        ovr    = 1'b1;
                        rd_ptr = next_slot(rd_ptr);
                        fill--;
                    end
                    ring[wr_ptr[RING_W-1:0]] = it.data_in;
                    wr_ptr = next_slot(wr_ptr);
                    fill++;
                    push_result(8'd0, 1'b0, ovr, 8'd0, 1'b1);
                end
                FUNC_GET: begin
                    if (fill == 0) begin
                        push_result(8'd0, 1'b0, 1'b0, 8'd0, 1'b1);
                    end else begin
                        b      = ring[rd_ptr[RING_W-1:0]];
                        rd_ptr = next_slot(rd_ptr);
                        fill--;
                        push_result(b, 1'b1, 1'b0, 8'd0, 1'b1);
                    end
                end
                FUNC_LINE: begin
                    // Up to limit minus one bytes, capped, stopping after a carriage return.
                    budget = (it.line_limit == 0) ? 0 : it.line_limit - 1;
                    if (budget > MAX_LINE) begin
                        budget = MAX_LINE;
                    end
                    count = 0;
                    nread = 0;
                    done  = 1'b0;
                    while (nread < budget && fill != 0 && !done) begin
                        b      = ring[rd_ptr[RING_W-1:0]];
                        rd_ptr = next_slot(rd_ptr);
                        fill--;
                        nread++;
                        is_cr = (b == CHAR_CR);
                        done  = is_cr || nread >= budget || fill == 0;
                        if (!is_cr) begin
                            count++;
                        end
                        push_result(b, 1'b1, 1'b0, done ? count[7:0] : 8'd0, done);
                    end
                    if (nread == 0) begin
                        push_result(8'd0, 1'b0, 1'b0, 8'd0, 1'b1);
                    end
                end
                default: begin
                    push_result(8'd0, 1'b0, 1'b0, 8'd0, 1'b1);
                end
            endcase
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // Called on every result transfer; compares it with the oldest prediction.
        function void check_response(out_item_t got);
            out_item_t want;
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
                want = results_due.pop_front();
                check_field("data_out", 32'(want.data_out), 32'(got.data_out));
                check_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
                check_field("overwrote", 32'(want.overwrote), 32'(got.overwrote));
                check_field("line_count", 32'(want.line_count), 32'(got.line_count));
                check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
                check_field("free_space", 32'(want.free_space), 32'(got.free_space));
                check_field("last", 32'(want.last), 32'(got.last));
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;
    logic             cfg_wr_en;
    logic [LEN_W-1:0] cfg_wr_data;

    bit               calm;
    int unsigned      idle_cycles;
    fifo_scoreboard   sb;

    byte_ring_fifo_overwrite_line_read_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Result side: random stall bursts, none once the run turns calm.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    // Monitor both channels at the clock edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_request(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check_response(m_data);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_byte_ring_fifo_overwrite_line_read_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one item, after an optional gap, and hold it until the transfer.
    task automatic send_item(input logic [1:0] f, input logic [7:0] d, input logic [7:0] lim);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{func: f, data_in: d, line_limit: lim};
        do @(posedge aclk); while (!s_ready);
    endtask

    // Wait until every predicted result has arrived, then write the length.
    task automatic write_length(input logic [LEN_W-1:0] v);
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.results_due.size() != 0);
        repeat (3) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_length(v);
    endtask

    // Random traffic: complete lines followed by a get line, single puts, gets, get lines and unused codes.
    task automatic run_mix(input int n);
        int         sent;
        int         len;
        int         pick;
        logic [7:0] b;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                len = $urandom_range(0, 8);
                repeat (len) begin
                    b = 8'($urandom_range(0, 255));
                    send_item(FUNC_PUT, b, 8'($urandom_range(0, 255)));
                end
                send_item(FUNC_PUT, CHAR_CR, 8'($urandom_range(0, 255)));
                send_item(FUNC_LINE, 8'($urandom_range(0, 255)),
                          8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(len + 2, 80)));
                sent += len + 2;
            end else if (pick < 55) begin
                b = ($urandom_range(0, 5) == 0) ? CHAR_CR : 8'($urandom_range(0, 255));
                send_item(FUNC_PUT, b, 8'($urandom_range(0, 255)));
                sent++;
            end else if (pick < 72) begin
                send_item(FUNC_GET, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                sent++;
            end else if (pick < 94) begin
                send_item(FUNC_LINE, 8'($urandom_range(0, 255)),
                          8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 12)));
                sent++;
            end else begin
                send_item(FUNC_UNUSED, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    initial begin
        sb          = new();
        calm        = 1'b0;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset length: overfill the ring, then read from it with one long line and a get.
        repeat (66) send_item(FUNC_PUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_item(FUNC_LINE, 8'h00, 8'hFF);
        send_item(FUNC_GET, 8'hFF, 8'h00);

        // Directed checks on a four-byte ring.
        write_length(7'd4);
        send_item(FUNC_PUT, 8'h00, 8'hFF);
        send_item(FUNC_PUT, 8'hFF, 8'h00);
        send_item(FUNC_PUT, CHAR_CR, 8'h01);
        send_item(FUNC_PUT, 8'hA5, 8'h80);
        // The ring is full, so this put drops the oldest byte.
        send_item(FUNC_PUT, 8'h5A, 8'h7F);
        send_item(FUNC_GET, 8'h00, 8'h00);
        // Limits of zero and one read nothing.
        send_item(FUNC_LINE, 8'h00, 8'h00);
        send_item(FUNC_LINE, 8'h00, 8'h01);
        // A line that is only a carriage return has a count of zero.
        send_item(FUNC_LINE, 8'h00, 8'hFF);
        send_item(FUNC_GET, 8'h00, 8'h00);
        send_item(FUNC_GET, 8'h00, 8'h00);
        send_item(FUNC_GET, 8'hFF, 8'hFF);
        send_item(FUNC_LINE, 8'h00, 8'hFF);
        send_item(FUNC_UNUSED, 8'hFF, 8'hFF);
        send_item(FUNC_PUT, 8'h61, 8'h00);
        send_item(FUNC_PUT, 8'h62, 8'h00);
        send_item(FUNC_PUT, CHAR_CR, 8'h00);
        send_item(FUNC_PUT, 8'h63, 8'h00);
        // The first line stops at the carriage return, the second when empty.
        send_item(FUNC_LINE, 8'h00, 8'hFF);
        send_item(FUNC_LINE, 8'h00, 8'h02);
        send_item(FUNC_PUT, 8'h78, 8'h00);
        send_item(FUNC_PUT, 8'h79, 8'h00);
        // A limit of two allows one byte.
        send_item(FUNC_LINE, 8'h00, 8'h02);
        send_item(FUNC_LINE, 8'h00, 8'hFF);

        // Random phases over several lengths, out-of-range values included.
        write_length(7'd0);
        run_mix(30);
        write_length(7'd127);
        run_mix(40);
        write_length(LEN_W'($urandom_range(2, 63)));
        run_mix(35);
        write_length(7'd1);
        run_mix(25);
        calm = 1'b1;
        write_length(7'd64);
        run_mix(30);

        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.results_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb_byte_ring_fifo_overwrite_line_read_top: clean");
        end else begin
            $display("tb_byte_ring_fifo_overwrite_line_read_top: errors");
        end
        $finish;
    end

endmodule
